FILE: design/mfpb_pkg.sv
package mfpb_pkg;

   // picture geometry
   localparam int WIDTH  = 128;
   localparam int HEIGHT = 128;
   localparam int COL_W  = $clog2(WIDTH);
   localparam int ROW_W  = $clog2(HEIGHT);

   // page number carried in the page select command
   localparam int PAGE_W = 4;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // panel command bytes
   localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
   localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
   localparam logic [7:0] CMD_COL_LOW   = 8'h00;

   // register map, selected by paddr[2]
   localparam logic REG_ENABLE    = 1'b0;
   localparam logic REG_THRESHOLD = 1'b1;
   localparam int   ADDR_W        = 3;

   localparam logic [7:0] THRESHOLD_RESET = 8'd128;

   // one packed column byte, with or without the command burst ahead of it
   typedef struct packed {
      logic [7:0]        data;
      logic              with_cmd;
      logic [PAGE_W-1:0] page;
   } job_type;

   // queue status seen by the front and the back
   typedef struct packed {
      logic              head_valid;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

endpackage

FILE: design/mfpb_front.sv
module mfpb_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_pixel,
   input  logic                      req_frame_start,
   input  logic                      enable,
   input  logic [7:0]                threshold,
   input  mfpb_pkg::queue_status_type queue_status,
   output logic                      push_valid,
   output mfpb_pkg::job_type         push_job
);

   localparam logic [mfpb_pkg::COL_W-1:0] COL_LAST = mfpb_pkg::COL_W'(mfpb_pkg::WIDTH - 1);
   localparam logic [mfpb_pkg::ROW_W-1:0] ROW_LAST = mfpb_pkg::ROW_W'(mfpb_pkg::HEIGHT - 1);

   logic [mfpb_pkg::COL_W-1:0]  col_ff, col_in, col_cur;
   logic [mfpb_pkg::ROW_W-1:0]  row_ff, row_in, row_cur;
   logic [2:0]                  sub;
   logic [2:0]                  pos;
   logic                        bit_lit;
   logic                        accept;
   logic                        store;
   logic                        fetch;
   logic [mfpb_pkg::QCNT_W:0]   occupancy;

   logic [6:0]                  page_mem [mfpb_pkg::WIDTH];
   logic [6:0]                  rd_ff;

   logic                        s1_valid_ff;
   logic                        s1_bit_ff;
   logic                        s1_first_ff;
   logic [mfpb_pkg::PAGE_W-1:0] s1_page_ff;

   // room for the item in flight plus the one accepted now
   assign occupancy = {1'b0, queue_status.count} + (mfpb_pkg::QCNT_W + 1)'(s1_valid_ff);
   assign req_ready = occupancy < (mfpb_pkg::QCNT_W + 1)'(mfpb_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   // position of this pixel, frame start forces the origin
   assign col_cur = req_frame_start ? '0 : col_ff;
   assign row_cur = req_frame_start ? '0 : row_ff;
   assign sub     = row_cur[2:0];
   assign pos     = 3'd6 - sub;
   assign bit_lit = req_pixel >= threshold;

   // rows 0..6 of a page are stored, row 7 reads the column back when enabled
   assign store = accept && (sub != 3'd7);
   assign fetch = accept && (sub == 3'd7) && enable;

   // raster counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_cur == COL_LAST) begin
            col_in = '0;
            row_in = (row_cur == ROW_LAST) ? '0 : row_cur + 1'b1;
         end else begin
            col_in = col_cur + 1'b1;
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= fetch;
      end
   end

   // column bit store, one bit written per pixel of rows 0..6
   always_ff @(posedge clock) begin
      if (store) begin
         page_mem[col_cur][pos] <= bit_lit;
      end
      if (fetch) begin
         rd_ff <= page_mem[col_cur];
      end
   end

   // fetch stage payload
   always_ff @(posedge clock) begin
      if (fetch) begin
         s1_bit_ff   <= bit_lit;
         s1_first_ff <= (col_cur == '0);
         s1_page_ff  <= mfpb_pkg::PAGE_W'(row_cur >> 3);
      end
   end

   // packed byte, top row in bit 7
   assign push_valid        = s1_valid_ff;
   assign push_job.data     = {rd_ff, s1_bit_ff};
   assign push_job.with_cmd = s1_first_ff;
   assign push_job.page     = s1_page_ff;

endmodule

FILE: design/mfpb_queue.sv
module mfpb_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  mfpb_pkg::job_type          push_job,
   input  logic                       pop,
   output mfpb_pkg::job_type          head_job,
   output mfpb_pkg::queue_status_type queue_status
);

   mfpb_pkg::job_type                 slot_ff [mfpb_pkg::QUEUE_DEPTH];
   logic [mfpb_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [mfpb_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [mfpb_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_pop;

   assign do_pop = pop && (count_ff != '0);

   // pointers and fill count
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + mfpb_pkg::QCNT_W'(push_valid) - mfpb_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job slots
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job                = slot_ff[rd_ptr_ff];
   assign queue_status.head_valid = count_ff != '0;
   assign queue_status.count      = count_ff;

endmodule

FILE: design/mfpb_back.sv
module mfpb_back (
   input  logic                       clock,
   input  logic                       reset,
   input  mfpb_pkg::job_type          head_job,
   input  mfpb_pkg::queue_status_type queue_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_panel_byte,
   output logic                       rsp_is_command,
   output logic                       rsp_last
);

   // burst steps
   localparam logic [1:0] STEP_PAGE = 2'd0;
   localparam logic [1:0] STEP_HIGH = 2'd1;
   localparam logic [1:0] STEP_LOW  = 2'd2;
   localparam logic [1:0] STEP_DATA = 2'd3;

   logic [1:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       cmd_ff, cmd_in;
   logic       last_ff, last_in;
   logic       load;
   logic       emit;

   // output register takes a new byte when empty or being taken
   assign load = !rsp_valid_ff || rsp_ready;
   assign emit = load && queue_status.head_valid;

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      cmd_in       = cmd_ff;
      last_in      = last_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = queue_status.head_valid;
      end
      if (emit) begin
         if (head_job.with_cmd) begin
            case (step_ff)
               STEP_PAGE: begin
                  byte_in = mfpb_pkg::CMD_PAGE_BASE | {4'h0, head_job.page};
                  cmd_in  = 1'b1;
                  last_in = 1'b0;
                  step_in = STEP_HIGH;
               end
               STEP_HIGH: begin
                  byte_in = mfpb_pkg::CMD_COL_HIGH;
                  cmd_in  = 1'b1;
                  last_in = 1'b0;
                  step_in = STEP_LOW;
               end
               STEP_LOW: begin
                  byte_in = mfpb_pkg::CMD_COL_LOW;
                  cmd_in  = 1'b1;
                  last_in = 1'b0;
                  step_in = STEP_DATA;
               end
               default: begin
                  byte_in = head_job.data;
                  cmd_in  = 1'b0;
                  last_in = 1'b1;
                  step_in = STEP_PAGE;
                  pop     = 1'b1;
               end
            endcase
         end else begin
            byte_in = head_job.data;
            cmd_in  = 1'b0;
            last_in = 1'b1;
            step_in = STEP_PAGE;
            pop     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_PAGE;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      cmd_ff  <= cmd_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_panel_byte = byte_ff;
   assign rsp_is_command = cmd_ff;
   assign rsp_last       = last_ff;

endmodule

FILE: design/mono_framebuffer_to_page_bytes.sv
// channel   direction  handshake             payload
// req       in         req_valid/req_ready   req_pixel[7:0], req_frame_start
// rsp       out        rsp_valid/rsp_ready   rsp_panel_byte[7:0], rsp_is_command, rsp_last
// csr       in         psel/penable/pready   paddr[2:0], pwdata[31:0], prdata[31:0]
//
// one pixel per cycle is accepted while the job queue has room; a pixel of a page's
// eighth row reaches rsp through the column store read, the job queue and the output register
// column 0 of that row gives four bytes, and the front keeps taking pixels until the
// four-entry job queue is full
// reset is synchronous: counters cleared, enable 0, threshold 128, column store
// holds no defined value until rows are written
module mono_framebuffer_to_page_bytes (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_pixel,
   input  logic                        req_frame_start,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_panel_byte,
   output logic                        rsp_is_command,
   output logic                        rsp_last,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [mfpb_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   logic                       enable_ff, enable_in;
   logic [7:0]                 threshold_ff, threshold_in;
   logic                       csr_write;
   logic                       push_valid;
   mfpb_pkg::job_type          push_job;
   mfpb_pkg::job_type          head_job;
   mfpb_pkg::queue_status_type queue_status;
   logic                       pop;

   // configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      enable_in    = enable_ff;
      threshold_in = threshold_ff;
      if (csr_write) begin
         case (paddr[2])
            mfpb_pkg::REG_ENABLE:    enable_in    = pwdata[0];
            mfpb_pkg::REG_THRESHOLD: threshold_in = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         threshold_ff <= mfpb_pkg::THRESHOLD_RESET;
      end else begin
         enable_ff    <= enable_in;
         threshold_ff <= threshold_in;
      end
   end

   // register read back
   assign prdata = (paddr[2] == mfpb_pkg::REG_THRESHOLD) ? {24'h0, threshold_ff}
                                                         : {31'h0, enable_ff};

   mfpb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .enable          (enable_ff),
      .threshold       (threshold_ff),
      .queue_status    (queue_status),
      .push_valid      (push_valid),
      .push_job        (push_job)
   );

   mfpb_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_valid   (push_valid),
      .push_job     (push_job),
      .pop          (pop),
      .head_job     (head_job),
      .queue_status (queue_status)
   );

   mfpb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_job       (head_job),
      .queue_status   (queue_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_panel_byte (rsp_panel_byte),
      .rsp_is_command (rsp_is_command),
      .rsp_last       (rsp_last)
   );

endmodule
